/* rtl/core/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants of the envelope stream deframer.
// ----------------------------------------------------------------------------
package esd_pkg;

  // An envelope header is 18 bytes; the first 17 are held until the last arrives.
  localparam int unsigned HDR_BYTES       = 18;
  localparam int unsigned HDR_STORE_DEPTH = HDR_BYTES - 1;
  localparam int unsigned HDR_CNT_W       = $clog2(HDR_STORE_DEPTH + 1);

  // Byte offsets of the header fields.
  localparam int unsigned OFS_CHANNEL  = 0;
  localparam int unsigned OFS_PRIORITY = 2;
  localparam int unsigned OFS_FLAGS    = 3;
  localparam int unsigned OFS_MSG_ID   = 4;
  localparam int unsigned OFS_TOTAL    = 8;
  localparam int unsigned OFS_SEQ      = 12;
  localparam int unsigned OFS_PSIZE    = 14;

  // Result kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [15:0] channel_id;
    logic [7:0]  priority_res;
    logic [7:0]  flags;
    logic [31:0] message_id;
    logic [31:0] total_length;
    logic [15:0] sequence_res;
    logic [31:0] payload_size;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  // Parser status seen by the top level checks.
  typedef struct packed {
    logic     in_payload;
    logic     left_zero;
    hdr_cnt_t hdr_cnt;
  } parse_status_t;

endpackage

/* rtl/core/esd_parse.sv */
// ----------------------------------------------------------------------------
// esd_parse
// Frame state, header byte store and single-pass result decode.
// ----------------------------------------------------------------------------
module esd_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  output logic                   res_valid_o,
  output esd_pkg::res_t          res_o,
  output esd_pkg::parse_status_t status_o
);

  logic               in_payload_r, in_payload_nxt;
  esd_pkg::hdr_cnt_t  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]        left_r, left_nxt;
  logic [7:0]         hdr_r [esd_pkg::HDR_STORE_DEPTH];

  logic               hdr_filling;
  logic [31:0]        left_dec;
  logic [31:0]        psize;

  // Header bytes are still being collected while the count is below the store depth.
  assign hdr_filling = (hdr_cnt_r < esd_pkg::HDR_CNT_W'(esd_pkg::HDR_STORE_DEPTH));
  assign left_dec    = (left_r == 32'd0) ? 32'd0 : left_r - 32'd1;
  assign psize       = {data_byte_i,
                        hdr_r[esd_pkg::OFS_PSIZE + 2],
                        hdr_r[esd_pkg::OFS_PSIZE + 1],
                        hdr_r[esd_pkg::OFS_PSIZE]};

  // Next state and result for the byte being accepted.
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    left_nxt       = left_r;
    res_valid_o    = 1'b0;
    res_o          = '0;
    if (accept_i) begin
      if (in_payload_r) begin
        res_valid_o        = 1'b1;
        res_o.kind         = esd_pkg::KIND_PAYLOAD;
        res_o.payload_byte = data_byte_i;
        res_o.last         = (left_dec == 32'd0);
        left_nxt           = left_dec;
        if (left_dec == 32'd0) begin
          in_payload_nxt = 1'b0;
        end
      end else if (hdr_filling) begin
        hdr_cnt_nxt = hdr_cnt_r + esd_pkg::HDR_CNT_W'(1);
      end else begin
        res_valid_o        = 1'b1;
        res_o.kind         = esd_pkg::KIND_HEADER;
        res_o.channel_id   = {hdr_r[esd_pkg::OFS_CHANNEL + 1], hdr_r[esd_pkg::OFS_CHANNEL]};
        res_o.priority_res = hdr_r[esd_pkg::OFS_PRIORITY];
        res_o.flags        = hdr_r[esd_pkg::OFS_FLAGS];
        res_o.message_id   = {hdr_r[esd_pkg::OFS_MSG_ID + 3], hdr_r[esd_pkg::OFS_MSG_ID + 2],
                              hdr_r[esd_pkg::OFS_MSG_ID + 1], hdr_r[esd_pkg::OFS_MSG_ID]};
        res_o.total_length = {hdr_r[esd_pkg::OFS_TOTAL + 3], hdr_r[esd_pkg::OFS_TOTAL + 2],
                              hdr_r[esd_pkg::OFS_TOTAL + 1], hdr_r[esd_pkg::OFS_TOTAL]};
        res_o.sequence_res = {hdr_r[esd_pkg::OFS_SEQ + 1], hdr_r[esd_pkg::OFS_SEQ]};
        res_o.payload_size = psize;
        res_o.last         = (psize == 32'd0);
        hdr_cnt_nxt        = '0;
        left_nxt           = psize;
        in_payload_nxt     = (psize != 32'd0);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      left_r       <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      left_r       <= left_nxt;
    end
  end

  // Header byte store, written at the current header position.
  always_ff @(posedge clk) begin
    if (accept_i && !in_payload_r && hdr_filling) begin
      hdr_r[hdr_cnt_r] <= data_byte_i;
    end
  end

  assign status_o.in_payload = in_payload_r;
  assign status_o.left_zero  = (left_r == 32'd0);
  assign status_o.hdr_cnt    = hdr_cnt_r;

endmodule

/* rtl/core/esd_outbuf.sv */
// ----------------------------------------------------------------------------
// esd_outbuf
// Result register with a skid stage, so input ready is a register output.
// ----------------------------------------------------------------------------
module esd_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  esd_pkg::res_t push_data_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output esd_pkg::res_t out_data_o
);

  logic          out_valid_r;
  logic          skid_valid_r;
  esd_pkg::res_t out_data_r;
  esd_pkg::res_t skid_data_r;
  logic          pop;

  assign pop = out_valid_r && out_ready_i;

  // Valid flags: the skid stage fills only when the result register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload moves.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push_i) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data_i;
      end else begin
        skid_data_r <= push_data_i;
      end
    end
  end

  assign space_o     = !skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

/* rtl/core/envelope_stream_deframer_top.sv */
// ----------------------------------------------------------------------------
// envelope_stream_deframer_top
// Splits a byte stream of back-to-back length-prefixed envelopes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data_byte) takes one raw byte
//   per request. Each envelope is an 18-byte little-endian header followed by
//   payload_size payload bytes. The output channel (out_valid, out_ready,
//   out_*) carries one header request when the last header byte arrives, then
//   one request per payload byte; out_last marks the final request of an
//   envelope (on the header itself when the payload size is zero).
//   Throughput is one byte per cycle while in_ready is high: every byte is
//   decoded in a single pass and its request is registered in the result
//   register, or in the skid stage when the result register is stalled.
//   A skid stage behind the result register holds one more request; in_ready
//   drops only while that stage is full, i.e. after the receiver has stalled
//   with two requests pending. in_ready is a register output.
//   Reset (rst_n low, synchronous) returns the block to expecting a header
//   and empties the output stages. Incomplete frames just wait for bytes.
// ----------------------------------------------------------------------------
module envelope_stream_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_channel_id,
  output logic [7:0]  out_priority_res,
  output logic [7:0]  out_flags,
  output logic [31:0] out_message_id,
  output logic [31:0] out_total_length,
  output logic [15:0] out_sequence_res,
  output logic [31:0] out_payload_size,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  logic                   accept;
  logic                   res_valid;
  esd_pkg::res_t          res;
  esd_pkg::res_t          out_data;
  esd_pkg::parse_status_t status;

  assign accept = in_valid && in_ready;

  // Frame parser and decoder.
  esd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .data_byte_i (in_data_byte),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // Result register and skid stage.
  esd_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_channel_id   = out_data.channel_id;
  assign out_priority_res = out_data.priority_res;
  assign out_flags        = out_data.flags;
  assign out_message_id   = out_data.message_id;
  assign out_total_length = out_data.total_length;
  assign out_sequence_res = out_data.sequence_res;
  assign out_payload_size = out_data.payload_size;
  assign out_payload_byte = out_data.payload_byte;
  assign out_last         = out_data.last;

  // While in the payload there is always at least one payload byte still due.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    status.in_payload |-> !status.left_zero)
    else $error("payload phase with no bytes left");

  // The header count never passes the store depth.
  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    status.hdr_cnt <= esd_pkg::HDR_CNT_W'(esd_pkg::HDR_STORE_DEPTH))
    else $error("header count beyond store depth");

  // Backpressure on the input only while the result register holds a request.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // A header request in the payload phase is never produced.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && status.in_payload) |-> (res.kind == esd_pkg::KIND_PAYLOAD))
    else $error("header result during payload");

endmodule
